// File: hdl/crcaf_pkg.sv
// ----------------------------------------------------------------------------
// crcaf_pkg
// Shared types, constants and the byte-wise CRC-A update for the frame checker.
// ----------------------------------------------------------------------------
package crcaf_pkg;

  localparam int unsigned FRAME_BUF_BYTES_DEF = 64;

  localparam int unsigned IDX_W = 9;

  localparam logic [7:0]  SYNC_BYTE = 8'h55;
  localparam logic [15:0] CRC_INIT  = 16'h6363;
  localparam logic [8:0]  LEN_SUM   = 9'h0FF;

  // Header positions within a frame.
  localparam logic [IDX_W-1:0] IDX_SYNC    = 9'd0;
  localparam logic [IDX_W-1:0] IDX_CMD     = 9'd1;
  localparam logic [IDX_W-1:0] IDX_LEN     = 9'd2;
  localparam logic [IDX_W-1:0] IDX_LEN_INV = 9'd3;
  localparam logic [IDX_W-1:0] HDR_BYTES   = 9'd4;

  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_BAD_SYNC = 2'd1,
    VERDICT_BAD_LEN  = 2'd2,
    VERDICT_BAD_CRC  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] payload_len;
    logic [7:0] command;
    verdict_t   verdict;
  } result_t;

  // One byte of CRC-A (ISO/IEC 14443-3 type A), reflected form.
  function automatic logic [15:0] crc_a_update(input logic [15:0] crc,
                                               input logic [7:0]  data);
    logic [7:0] b;
    b = data ^ crc[7:0];
    b = b ^ {b[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000}
           ^ {12'h000, b[7:4]};
  endfunction

endpackage

// File: hdl/crc_a_frame_checker.sv
// ----------------------------------------------------------------------------
// crc_a_frame_checker
// Checks received byte frames (sync, command, length, inverted length,
// payload, CRC-A) and gives one verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the input stream while
// in_tready is high and keeps its frame state (byte position, running CRC-A,
// held command and length) in registers, so a new byte can be accepted in
// every such cycle; a frame's verdict goes to the output register, or to the
// skid register while the head is stalled. A byte with in_tuser high starts
// a frame; its data must be the sync byte 0x55. One result item is produced
// per frame: ok, bad sync, bad length (length plus inverted length is not
// 0xFF, or the length is not below FRAME_BUF_BYTES-2) or bad CRC. Bytes after
// a verdict, and bytes before the first block start, are consumed without any
// effect. A block start in the middle of a frame drops that frame without a
// verdict. Results sit in a two-entry output buffer (output register plus
// skid register), so the input keeps accepting bytes while one verdict waits
// downstream; in_tready falls only when both entries are full.
// ----------------------------------------------------------------------------
module crc_a_frame_checker #(
  parameter int unsigned FRAME_BUF_BYTES = crcaf_pkg::FRAME_BUF_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] block_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] verdict, [9:2] command, [17:10] payload_len, [23:18] zero
  output logic [crcaf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import crcaf_pkg::*;

  // Length limit as a 9-bit value, so a limit of 256 still compares right.
  localparam logic [8:0] LEN_LIMIT = 9'(FRAME_BUF_BYTES - 2);

  // Frame state.
  logic [IDX_W-1:0] idx_r,  idx_nxt;
  logic [15:0]      crc_r,  crc_nxt;
  logic [7:0]       len_r,  len_nxt;
  logic [7:0]       cmd_r,  cmd_nxt;
  logic             done_r, done_nxt;
  logic             lowm_r, lowm_nxt;

  // Output buffer: the head register drives the port, the skid register
  // catches a verdict that arrives while the head is stalled.
  result_t          out_r,        out_nxt;
  logic             out_valid_r,  out_valid_nxt;
  result_t          skid_r,       skid_nxt;
  logic             skid_valid_r, skid_valid_nxt;

  logic             accept;
  logic             pop;
  logic             emit;
  result_t          res;

  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  // Frame tracking and verdict decision for the byte being accepted.
  always_comb begin
    logic [IDX_W-1:0] idx_cur;
    logic [IDX_W-1:0] crc_pos;
    logic [15:0]      crc_cur;
    logic [7:0]       len_cur;
    logic [7:0]       cmd_cur;
    logic             done_cur;
    logic             lowm_cur;

    // A block start clears the frame before this byte is looked at.
    if (in_tuser) begin
      idx_cur  = IDX_SYNC;
      crc_cur  = CRC_INIT;
      len_cur  = 8'h00;
      cmd_cur  = 8'h00;
      done_cur = 1'b0;
      lowm_cur = 1'b0;
    end else begin
      idx_cur  = idx_r;
      crc_cur  = crc_r;
      len_cur  = len_r;
      cmd_cur  = cmd_r;
      done_cur = done_r;
      lowm_cur = lowm_r;
    end

    crc_pos = HDR_BYTES + {1'b0, len_cur};

    idx_nxt  = idx_cur;
    crc_nxt  = crc_cur;
    len_nxt  = len_cur;
    cmd_nxt  = cmd_cur;
    done_nxt = done_cur;
    lowm_nxt = lowm_cur;
    emit     = 1'b0;
    res      = '{payload_len: len_cur, command: cmd_cur, verdict: VERDICT_OK};

    if (!done_cur) begin
      idx_nxt = idx_cur + 9'd1;
      if (idx_cur == IDX_SYNC) begin
        if (in_tdata != SYNC_BYTE) begin
          emit = 1'b1;
          res  = '{payload_len: 8'h00, command: 8'h00, verdict: VERDICT_BAD_SYNC};
        end else begin
          crc_nxt = crc_a_update(crc_cur, in_tdata);
        end
      end else if (idx_cur == IDX_CMD) begin
        cmd_nxt = in_tdata;
        crc_nxt = crc_a_update(crc_cur, in_tdata);
      end else if (idx_cur == IDX_LEN) begin
        len_nxt = in_tdata;
        crc_nxt = crc_a_update(crc_cur, in_tdata);
      end else if (idx_cur == IDX_LEN_INV) begin
        if (({1'b0, len_cur} + {1'b0, in_tdata}) != LEN_SUM ||
            {1'b0, len_cur} >= LEN_LIMIT) begin
          emit        = 1'b1;
          res.verdict = VERDICT_BAD_LEN;
        end else begin
          crc_nxt = crc_a_update(crc_cur, in_tdata);
        end
      end else if (idx_cur < crc_pos) begin
        crc_nxt = crc_a_update(crc_cur, in_tdata);
      end else if (idx_cur == crc_pos) begin
        lowm_nxt = (in_tdata == crc_cur[7:0]);
      end else begin
        emit        = 1'b1;
        res.verdict = (lowm_cur && in_tdata == crc_cur[15:8]) ? VERDICT_OK
                                                               : VERDICT_BAD_CRC;
      end
    end
    if (emit) begin
      done_nxt = 1'b1;
    end
  end

  // Two-entry result buffer, kept in order.
  always_comb begin
    logic push;
    push           = accept && emit;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = res;
        out_valid_nxt = push;
      end
    end else if (!out_valid_r) begin
      out_nxt       = res;
      out_valid_nxt = push;
    end else if (push) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= IDX_SYNC;
      crc_r        <= CRC_INIT;
      len_r        <= 8'h00;
      cmd_r        <= 8'h00;
      done_r       <= 1'b1;
      lowm_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r  <= idx_nxt;
        crc_r  <= crc_nxt;
        len_r  <= len_nxt;
        cmd_r  <= cmd_nxt;
        done_r <= done_nxt;
        lowm_r <= lowm_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_r.payload_len, out_r.command, out_r.verdict};

endmodule

// File: hdl/crcaf_checker.sv
// ----------------------------------------------------------------------------
// crcaf_checker
// Port-level assertions for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crcaf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [crcaf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import crcaf_pkg::*;

  // No verdict is left over from before a reset.
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid right after reset");

  // A stalled result item holds.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // A bad sync verdict never carries a command or a length.
  a_bad_sync_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == VERDICT_BAD_SYNC |-> out_tdata[17:2] == 16'h0000)
    else $error("bad sync verdict with nonzero command or length");

  // With the output empty the buffer has room, so bytes must be taken.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result buffer");

  // Padding bits of the result item stay zero.
  a_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:18] == 6'b000000)
    else $error("nonzero padding in result item");

endmodule

bind crc_a_frame_checker crcaf_checker u_crcaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
